### hw/rtl/open_addressing_hash_table_core_defines.svh
// Assertion macros for the checker file of the hash table core.
`ifndef OPEN_ADDRESSING_HASH_TABLE_CORE_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define OAHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define OAHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/oaht_pkg.sv
// Types, constants and codes shared by the hash table core modules.
package oaht_pkg;

  localparam int TABLE_DEPTH  = 32;
  localparam int KEY_BITS     = 16;
  localparam int SLOT_BITS    = $clog2(TABLE_DEPTH);
  localparam int SIZE_BITS    = $clog2(TABLE_DEPTH + 1);
  localparam int MOD_CNT_BITS = $clog2(KEY_BITS);
  localparam int COUNT_BITS   = 32;

  localparam int ACT_BITS      = 2;
  localparam int KEY_FLD_BITS  = 16;
  localparam int STATUS_BITS   = 3;
  localparam int SLOT_FLD_BITS = 5;
  localparam int PROBE_BITS    = 6;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 6;

  localparam logic [ACT_BITS-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_BITS-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACT_BITS-1:0] ACT_SEARCH = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_PRESENT  = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_FOUND    = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_CLEARED  = 3'd5;

  localparam logic [CFG_IDX_BITS-1:0] REG_PROBE_MODE = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TABLE_SIZE = 1'd1;

  localparam logic [CFG_DATA_BITS-1:0] TABLE_SIZE_RESET = 6'd29;

  typedef struct packed {
    logic [ACT_BITS-1:0]     action;
    logic [KEY_FLD_BITS-1:0] key;
  } req_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]   status;
    logic [SLOT_FLD_BITS-1:0] slot;
    logic [PROBE_BITS-1:0]    probes;
    logic [COUNT_BITS-1:0]    collision_total;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic mod_step;
    logic probe;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mod_last;
    logic probe_done;
  } dp_stat_t;

endpackage

### hw/rtl/oaht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module oaht_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/oaht_ctrl.sv
// Controller state machine sequencing clear, remainder and probe phases.
module oaht_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [oaht_pkg::ACT_BITS-1:0] action,
  input  oaht_pkg::dp_stat_t            stat,
  output oaht_pkg::ctrl_cmd_t           cmd,
  output logic                          busy
);

  import oaht_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MOD   = 2'd1;
  localparam logic [1:0] S_PROBE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (action)
            ACT_CLEAR: begin
              cmd.clear = 1'b1;
            end
            ACT_INSERT, ACT_SEARCH: begin
              cmd.load   = 1'b1;
              state_next = S_MOD;
            end
            default: begin
            end
          endcase
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        if (stat.probe_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

### hw/rtl/oaht_dp.sv
// Datapath: configuration, remainder unit, probe address walk, key store and totals.
module oaht_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  oaht_pkg::req_t                     request,
  input  oaht_pkg::ctrl_cmd_t                cmd,
  output oaht_pkg::dp_stat_t                 stat,
  input  logic                               cfg_valid,
  input  logic [oaht_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [oaht_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output logic                               done,
  output oaht_pkg::rsp_t                     result
);

  import oaht_pkg::*;

  logic                    probe_mode;
  logic [SIZE_BITS-1:0]    table_size;
  logic [SIZE_BITS-1:0]    m;

  logic [KEY_BITS-1:0]     key_q;
  logic [ACT_BITS-1:0]     action_q;
  logic [KEY_BITS-1:0]     mod_shift;
  logic [MOD_CNT_BITS-1:0] mod_cnt;
  logic [SIZE_BITS-1:0]    rem;
  logic [SIZE_BITS:0]      rem_ext;
  logic [SIZE_BITS-1:0]    rem_next;

  logic [SLOT_BITS-1:0]    addr;
  logic [SIZE_BITS-1:0]    step;
  logic [SIZE_BITS-1:0]    issue_cnt;
  logic [SIZE_BITS:0]      addr_sum;
  logic [SLOT_BITS-1:0]    addr_next;
  logic [SIZE_BITS:0]      step_a;
  logic [SIZE_BITS:0]      step_b;
  logic [SIZE_BITS-1:0]    step_next;

  logic                    cmp_valid;
  logic [SIZE_BITS-1:0]    cmp_idx;
  logic [SLOT_BITS-1:0]    cmp_slot;
  logic                    valid_q;
  logic [TABLE_DEPTH-1:0]  slot_valid;
  logic [KEY_BITS-1:0]     rd_key;

  logic                    key_hit;
  logic                    last;
  logic                    term;
  logic                    wr_en;
  logic [STATUS_BITS-1:0]  res_status;
  logic [SLOT_BITS-1:0]    res_slot;
  logic [SIZE_BITS-1:0]    res_probes;
  logic [SIZE_BITS-1:0]    coll_add;
  logic [COUNT_BITS-1:0]   coll_cnt;
  logic [COUNT_BITS:0]     coll_sum;
  logic [COUNT_BITS-1:0]   coll_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_mode <= 1'b0;
      table_size <= TABLE_SIZE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PROBE_MODE: probe_mode <= cfg_data[0];
        REG_TABLE_SIZE: table_size <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (table_size == '0) begin
      m = SIZE_BITS'(1);
    end else if (table_size > SIZE_BITS'(TABLE_DEPTH)) begin
      m = SIZE_BITS'(TABLE_DEPTH);
    end else begin
      m = table_size;
    end
  end

  always_comb begin
    rem_ext = {rem, mod_shift[KEY_BITS-1]};
    if (rem_ext >= {1'b0, m}) begin
      rem_ext = rem_ext - {1'b0, m};
    end
    rem_next = rem_ext[SIZE_BITS-1:0];
  end

  always_comb begin
    addr_sum = (SIZE_BITS+1)'(addr) + {1'b0, step};
    if (addr_sum >= {1'b0, m}) begin
      addr_sum = addr_sum - {1'b0, m};
    end
    addr_next = addr_sum[SLOT_BITS-1:0];
    step_a = {1'b0, step} + (SIZE_BITS+1)'(2);
    if (step_a >= {1'b0, m}) begin
      step_a = step_a - {1'b0, m};
    end
    step_b = step_a;
    if (step_b >= {1'b0, m}) begin
      step_b = step_b - {1'b0, m};
    end
    step_next = probe_mode ? step : step_b[SIZE_BITS-1:0];
  end

  assign stat.mod_last = (mod_cnt == MOD_CNT_BITS'(KEY_BITS - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q     <= request.key[KEY_BITS-1:0];
      action_q  <= request.action;
      mod_shift <= request.key[KEY_BITS-1:0];
      mod_cnt   <= '0;
      rem       <= '0;
    end else if (cmd.mod_step) begin
      mod_shift <= {mod_shift[KEY_BITS-2:0], 1'b0};
      mod_cnt   <= mod_cnt + MOD_CNT_BITS'(1);
      rem       <= rem_next;
    end
    if (cmd.mod_step && stat.mod_last) begin
      addr      <= rem_next[SLOT_BITS-1:0];
      step      <= (m == SIZE_BITS'(1)) ? '0 : SIZE_BITS'(1);
      issue_cnt <= '0;
    end else if (cmd.probe && (issue_cnt < m)) begin
      addr      <= addr_next;
      step      <= step_next;
      issue_cnt <= issue_cnt + SIZE_BITS'(1);
      cmp_idx   <= issue_cnt;
      cmp_slot  <= addr;
      valid_q   <= slot_valid[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= cmd.probe && (issue_cnt < m);
    end
  end

  oaht_ram #(
    .WIDTH(KEY_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_keys (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(cmp_slot),
    .wr_data(key_q),
    .rd_addr(addr),
    .rd_data(rd_key)
  );

  assign key_hit = (rd_key == key_q);
  assign last    = (cmp_idx == m - SIZE_BITS'(1));

  always_comb begin
    term       = 1'b0;
    wr_en      = 1'b0;
    res_status = ST_FULL;
    res_slot   = '0;
    res_probes = m;
    coll_add   = '0;
    if (action_q == ACT_INSERT) begin
      if (!valid_q) begin
        term       = 1'b1;
        wr_en      = cmd.probe && cmp_valid;
        res_status = ST_INSERTED;
        res_slot   = cmp_slot;
        res_probes = cmp_idx + SIZE_BITS'(1);
        coll_add   = cmp_idx;
      end else if (key_hit) begin
        term       = 1'b1;
        res_status = ST_PRESENT;
        res_slot   = cmp_slot;
        res_probes = cmp_idx + SIZE_BITS'(1);
      end else if (last) begin
        term       = 1'b1;
        res_status = ST_FULL;
      end
    end else begin
      if (valid_q && key_hit) begin
        term       = 1'b1;
        res_status = ST_FOUND;
        res_slot   = cmp_slot;
        res_probes = cmp_idx + SIZE_BITS'(1);
        coll_add   = cmp_idx;
      end else if (last) begin
        term       = 1'b1;
        res_status = ST_NOTFOUND;
        coll_add   = m;
      end
    end
  end

  assign stat.probe_done = cmd.probe && cmp_valid && term;

  assign coll_sum = {1'b0, coll_cnt} + (COUNT_BITS+1)'(coll_add);
  assign coll_sat = coll_sum[COUNT_BITS] ? '1 : coll_sum[COUNT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      coll_cnt   <= '0;
      done       <= 1'b0;
    end else begin
      done <= cmd.clear || stat.probe_done;
      if (cmd.clear) begin
        slot_valid <= '0;
        coll_cnt   <= '0;
      end else if (stat.probe_done) begin
        coll_cnt <= coll_sat;
        if (wr_en) begin
          slot_valid[cmp_slot] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      result.status          <= ST_CLEARED;
      result.slot            <= '0;
      result.probes          <= '0;
      result.collision_total <= '0;
    end else if (stat.probe_done) begin
      result.status          <= res_status;
      result.slot            <= SLOT_FLD_BITS'(res_slot);
      result.probes          <= PROBE_BITS'(res_probes);
      result.collision_total <= coll_sat;
    end
  end

endmodule

### hw/rtl/open_addressing_hash_table_core.sv
// Top level of the open-addressing hash table core.
//
//   channel   handshake              payload
//   request   start, busy            request (action, key)
//   result    done strobe            result (status, slot, probes, collision_total)
//   config    cfg_valid, cfg_ready   cfg_index, cfg_data
//
// Clear and unused actions keep busy low; a clear shows its result in the next cycle.
// Insert and search first take the key remainder, one key bit a cycle,
// then probe one slot a cycle through the single read port of the key RAM.
// An insert or search raises done as busy falls.
// Reset is synchronous; no clearing pass is needed. Results cannot be stalled.
module open_addressing_hash_table_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  oaht_pkg::req_t                     request,
  output logic                               done,
  output oaht_pkg::rsp_t                     result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [oaht_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [oaht_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  import oaht_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  oaht_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .action(request.action),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  oaht_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .cmd      (cmd),
    .stat     (stat),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .done     (done),
    .result   (result)
  );

endmodule

### hw/rtl/oaht_chk.sv
// Port-level checker for the hash table core, bound to the top level.
`include "open_addressing_hash_table_core_defines.svh"

module oaht_chk (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input oaht_pkg::req_t     request,
  input logic               done,
  input oaht_pkg::rsp_t     result
);

  import oaht_pkg::*;

  logic req_take;
  logic work_req;
  logic clear_req;
  logic cleared;
  logic zero_rsp;
  logic miss;

  assign req_take  = start && !busy;
  assign work_req  = req_take &&
                     (request.action == ACT_INSERT || request.action == ACT_SEARCH);
  assign clear_req = req_take && (request.action == ACT_CLEAR);
  assign cleared   = done && (result.status == ST_CLEARED);
  assign zero_rsp  = (result.probes == '0) && (result.collision_total == '0);
  assign miss      = (result.status == ST_FULL) || (result.status == ST_NOTFOUND);

  `OAHT_ASSERT_NEXT(a_work_busy, work_req, busy, "insert or search request did not raise busy")
  `OAHT_ASSERT_NEXT(a_clear_result, clear_req, cleared && !busy, "clear request not reported")
  `OAHT_ASSERT_NOW(a_cleared_zero, cleared, zero_rsp, "cleared result carries nonzero fields")
  `OAHT_ASSERT_NOW(a_miss_slot, done && miss, result.slot == '0, "failed request reports a slot")
  `OAHT_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")

endmodule

bind open_addressing_hash_table_core oaht_chk u_chk (.*);

### tb/sv/open_addressing_hash_table_core_test.sv
// Self-checking testbench for the open-addressing hash table core.
`timescale 1ns / 1ps

module open_addressing_hash_table_core_test;
  import oaht_pkg::*;

  localparam logic [ACT_BITS-1:0] ACT_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int QUIET_PHASE = 4;
  localparam int POOL_KEYS = 12;
  localparam int PLAN_ROWS = 33;

  typedef struct packed {
    logic                     is_cfg;
    req_t                     req;
    logic [CFG_IDX_BITS-1:0]  reg_idx;
    logic [CFG_DATA_BITS-1:0] reg_data;
    logic                     pinned;
    rsp_t                     exp;
  } dir_row_t;

  localparam req_t NO_REQ = '0;
  localparam rsp_t NO_RSP = '0;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t request;
  logic done;
  rsp_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  logic pin_valid;
  rsp_t pin_rsp;

  logic [KEY_BITS-1:0] keys_held [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] slot_used;
  logic [COUNT_BITS-1:0] collisions;
  logic step_linear;
  logic [CFG_DATA_BITS-1:0] size_reg;

  rsp_t outcomes_due [$];
  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int idle_cycles = 0;
  int status_seen [8];

  dir_row_t plan [PLAN_ROWS] = '{
    '{1'b0, '{ACT_CLEAR, 16'h0000}, REG_PROBE_MODE, 6'd0, 1'b1,
      '{ST_CLEARED, 5'd0, 6'd0, 32'd0}},
    '{1'b0, '{ACT_SEARCH, 16'h0000}, REG_PROBE_MODE, 6'd0, 1'b1,
      '{ST_NOTFOUND, 5'd0, 6'd29, 32'd29}},
    '{1'b0, '{ACT_INSERT, 16'h0000}, REG_PROBE_MODE, 6'd0, 1'b1,
      '{ST_INSERTED, 5'd0, 6'd1, 32'd29}},
    '{1'b0, '{ACT_INSERT, 16'h0000}, REG_PROBE_MODE, 6'd0, 1'b1,
      '{ST_PRESENT, 5'd0, 6'd1, 32'd29}},
    '{1'b0, '{ACT_INSERT, 16'd29}, REG_PROBE_MODE, 6'd0, 1'b0, NO_RSP},
    '{1'b0, '{ACT_INSERT, 16'hFFFF}, REG_PROBE_MODE, 6'd0, 1'b0, NO_RSP},
    '{1'b0, '{ACT_SEARCH, 16'hFFFF}, REG_PROBE_MODE, 6'd0, 1'b0, NO_RSP},
    '{1'b0, '{ACT_SEARCH, 16'd58}, REG_PROBE_MODE, 6'd0, 1'b0, NO_RSP},
    '{1'b0, '{ACT_UNUSED, 16'h5A5A}, REG_PROBE_MODE, 6'd0, 1'b0, NO_RSP},
    '{1'b1, NO_REQ, REG_PROBE_MODE, 6'h3F, 1'b0, NO_RSP},
    '{1'b1, NO_REQ, REG_TABLE_SIZE, 6'd0, 1'b0, NO_RSP},
    '{1'b0, '{ACT_CLEAR, 16'hFFFF}, REG_PROBE_MODE, 6'd0, 1'b1,
      '{ST_CLEARED, 5'd0, 6'd0, 32'd0}},
    '{1'b0, '{ACT_INSERT, 16'd5}, REG_PROBE_MODE, 6'd0, 1'b1,
      '{ST_INSERTED, 5'd0, 6'd1, 32'd0}},
    '{1'b0, '{ACT_INSERT, 16'd6}, REG_PROBE_MODE, 6'd0, 1'b1,
      '{ST_FULL, 5'd0, 6'd1, 32'd0}},
    '{1'b0, '{ACT_SEARCH, 16'd6}, REG_PROBE_MODE, 6'd0, 1'b1,
      '{ST_NOTFOUND, 5'd0, 6'd1, 32'd1}},
    '{1'b0, '{ACT_SEARCH, 16'd5}, REG_PROBE_MODE, 6'd0, 1'b1,
      '{ST_FOUND, 5'd0, 6'd1, 32'd1}},
    '{1'b1, NO_REQ, REG_PROBE_MODE, 6'h3E, 1'b0, NO_RSP},
    '{1'b1, NO_REQ, REG_TABLE_SIZE, 6'd63, 1'b0, NO_RSP},
    '{1'b0, '{ACT_INSERT, 16'd32}, REG_PROBE_MODE, 6'd0, 1'b0, NO_RSP},
    '{1'b0, '{ACT_INSERT, 16'd64}, REG_PROBE_MODE, 6'd0, 1'b0, NO_RSP},
    '{1'b0, '{ACT_INSERT, 16'd96}, REG_PROBE_MODE, 6'd0, 1'b0, NO_RSP},
    '{1'b0, '{ACT_INSERT, 16'd128}, REG_PROBE_MODE, 6'd0, 1'b0, NO_RSP},
    '{1'b0, '{ACT_INSERT, 16'd160}, REG_PROBE_MODE, 6'd0, 1'b0, NO_RSP},
    '{1'b0, '{ACT_INSERT, 16'd192}, REG_PROBE_MODE, 6'd0, 1'b0, NO_RSP},
    '{1'b0, '{ACT_INSERT, 16'd224}, REG_PROBE_MODE, 6'd0, 1'b0, NO_RSP},
    '{1'b1, NO_REQ, REG_PROBE_MODE, 6'h01, 1'b0, NO_RSP},
    '{1'b1, NO_REQ, REG_TABLE_SIZE, 6'd32, 1'b0, NO_RSP},
    '{1'b0, '{ACT_INSERT, 16'd224}, REG_PROBE_MODE, 6'd0, 1'b0, NO_RSP},
    '{1'b1, NO_REQ, REG_TABLE_SIZE, 6'd4, 1'b0, NO_RSP},
    '{1'b0, '{ACT_SEARCH, 16'd64}, REG_PROBE_MODE, 6'd0, 1'b0, NO_RSP},
    '{1'b0, '{ACT_INSERT, 16'd8}, REG_PROBE_MODE, 6'd0, 1'b0, NO_RSP},
    '{1'b0, '{ACT_SEARCH, 16'd8}, REG_PROBE_MODE, 6'd0, 1'b0, NO_RSP},
    '{1'b0, '{ACT_SEARCH, 16'd32}, REG_PROBE_MODE, 6'd0, 1'b0, NO_RSP}
  };

  open_addressing_hash_table_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int slots_in_use(input logic [CFG_DATA_BITS-1:0] size);
    if (size == 0) return 1;
    if (size > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(size);
  endfunction

  function automatic void add_collisions(input int n);
    logic [COUNT_BITS:0] sum;
    sum = {1'b0, collisions} + (COUNT_BITS + 1)'(n);
    collisions = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
  endfunction

  // Applies one request to the table copy and works out the result it should give; returns 0 for an unused action.
  function automatic bit table_outcome(input req_t r, output rsp_t o);
    int m;
    int i;
    int j;
    int hit_at;
    m = slots_in_use(size_reg);
    hit_at = -1;
    o = '0;
    case (r.action)
      ACT_CLEAR: begin
        slot_used = '0;
        collisions = '0;
        o.status = ST_CLEARED;
      end
      ACT_INSERT: begin
        o.status = ST_FULL;
        o.probes = PROBE_BITS'(m);
        for (i = 0; i < m; i++) begin
          j = ((int'(r.key) % m) + (step_linear ? i : i * i)) % m;
          if (!slot_used[j]) begin
            slot_used[j] = 1'b1;
            keys_held[j] = r.key;
            add_collisions(i);
            o.status = ST_INSERTED;
            hit_at = j;
          end else if (keys_held[j] == r.key) begin
            o.status = ST_PRESENT;
            hit_at = j;
          end
          if (hit_at >= 0) begin
            o.slot = SLOT_FLD_BITS'(hit_at);
            o.probes = PROBE_BITS'(i + 1);
            break;
          end
        end
      end
      ACT_SEARCH: begin
        o.status = ST_NOTFOUND;
        o.probes = PROBE_BITS'(m);
        for (i = 0; i < m; i++) begin
          j = ((int'(r.key) % m) + (step_linear ? i : i * i)) % m;
          if (slot_used[j] && keys_held[j] == r.key) begin
            o.status = ST_FOUND;
            o.slot = SLOT_FLD_BITS'(j);
            o.probes = PROBE_BITS'(i + 1);
            hit_at = i;
            break;
          end
        end
        add_collisions(hit_at >= 0 ? hit_at : m);
      end
      default: return 1'b0;
    endcase
    o.collision_total = collisions;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : observe
    rsp_t want;
    rsp_t worked;
    if (rst) begin
      slot_used = '0;
      collisions = '0;
      step_linear = 1'b0;
      size_reg = TABLE_SIZE_RESET;
      idle_cycles = 0;
    end else begin
      if (done) begin
        status_seen[result.status]++;
        if (outcomes_due.size() == 0) begin
          $error("result with no request outstanding, status %0d", result.status);
          errors++;
        end else begin
          want = outcomes_due.pop_front();
          checked++;
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            errors++;
          end
          if (result.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, result.slot);
            errors++;
          end
          if (result.probes !== want.probes) begin
            $error("probes: expected %0d, got %0d", want.probes, result.probes);
            errors++;
          end
          if (result.collision_total !== want.collision_total) begin
            $error("collision_total: expected %0d, got %0d",
                   want.collision_total, result.collision_total);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        accepted++;
        if (table_outcome(request, worked)) begin
          outcomes_due.push_back(pin_valid ? pin_rsp : worked);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PROBE_MODE) begin
          step_linear = cfg_data[0];
        end else begin
          size_reg = cfg_data;
        end
      end
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("open_addressing_hash_table_core test failed");
        $finish;
      end
    end
  end

  task automatic drain_results();
    while (outcomes_due.size() != 0) @(negedge clk);
  endtask

  task automatic issue(input req_t r, input logic pinned, input rsp_t exp, input bit may_idle);
    int gap;
    if (may_idle && $urandom_range(0, 99) < 8) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    request = r;
    pin_valid = pinned;
    pin_rsp = exp;
    start = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if ($urandom_range(0, 99) < 8) repeat ($urandom_range(1, 4)) @(negedge clk);
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin : stimulus
    req_t r;
    logic [CFG_DATA_BITS-1:0] size;
    logic [KEY_FLD_BITS-1:0] pool [POOL_KEYS];
    int m;
    int pick;
    int counted;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    pin_valid = 1'b0;
    pin_rsp = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    foreach (status_seen[s]) status_seen[s] = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    foreach (plan[n]) begin
      if (plan[n].is_cfg) begin
        write_reg(plan[n].reg_idx, plan[n].reg_data);
      end else begin
        issue(plan[n].req, plan[n].pinned, plan[n].exp, 1'b1);
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_reg(REG_PROBE_MODE, CFG_DATA_BITS'($urandom_range(0, 63)));
      pick = $urandom_range(0, 9);
      if (pick < 6) size = CFG_DATA_BITS'($urandom_range(1, 8));
      else if (pick == 6) size = '0;
      else if (pick == 7) size = CFG_DATA_BITS'(TABLE_DEPTH);
      else if (pick == 8) size = CFG_DATA_BITS'($urandom_range(TABLE_DEPTH + 1, 63));
      else size = CFG_DATA_BITS'($urandom_range(9, TABLE_DEPTH - 1));
      write_reg(REG_TABLE_SIZE, size);

      // Most keys share a few home slots so that probing chains grow long.
      m = slots_in_use(size);
      foreach (pool[k]) begin
        pool[k] = (k < 9) ? KEY_FLD_BITS'((k % 3) + m * $urandom_range(0, 65533 / m))
                          : KEY_FLD_BITS'($urandom_range(0, 65535));
      end

      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) r.action = ACT_CLEAR;
        else if (pick < 8) r.action = ACT_UNUSED;
        else if (pick < 54) r.action = ACT_INSERT;
        else r.action = ACT_SEARCH;
        r.key = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, POOL_KEYS - 1)]
                                           : KEY_FLD_BITS'($urandom_range(0, 65535));
        if ($urandom_range(0, 99) == 0) drain_results();
        issue(r, 1'b0, NO_RSP, phase != QUIET_PHASE);
        if (r.action != ACT_UNUSED) counted++;
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Covered %0d requests over %0d random table settings; %0d results checked.",
             accepted, RANDOM_PHASES, checked);
    $display("Inserted %0d, present %0d, full %0d, found %0d, not found %0d, cleared %0d.",
             status_seen[ST_INSERTED], status_seen[ST_PRESENT], status_seen[ST_FULL],
             status_seen[ST_FOUND], status_seen[ST_NOTFOUND], status_seen[ST_CLEARED]);
    if (errors == 0) begin
      $display("open_addressing_hash_table_core test passed");
    end else begin
      $display("open_addressing_hash_table_core test failed");
    end
    $finish;
  end

endmodule
